### rtl/cidr_source_allowlist_defines.svh
`ifndef CIDR_SOURCE_ALLOWLIST_DEFINES_SVH
`define CIDR_SOURCE_ALLOWLIST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csa: implication check failed");

// Next-cycle implication, checked outside reset.
`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csa: next-cycle check failed");

`endif

### rtl/csa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int ADDR_W  = 64;
  localparam int IDX_W   = 6;
  localparam int PLEN_W  = 8;
  localparam int LEN_W   = 7;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = 9;
  localparam int CFG_W   = 7;

  localparam logic [PLEN_W-1:0] PLEN_V6   = 8'd128;
  localparam logic [PLEN_W-1:0] PLEN_HALF = 8'd64;
  localparam logic [PLEN_W-1:0] PLEN_V4   = 8'd32;

  typedef enum logic [2:0] {
    VERDICT_MATCHED     = 3'd0,
    VERDICT_EMPTY_LOCAL = 3'd1,
    VERDICT_EMPTY_NET   = 3'd2,
    VERDICT_NO_PEER     = 3'd3,
    VERDICT_NO_MATCH    = 3'd4,
    VERDICT_WRITTEN     = 3'd5
  } verdict_t;

  typedef enum logic [0:0] {
    CFG_ENTRY_COUNT    = 1'b0,
    CFG_LISTENER_LOCAL = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Stored entry: address and the mask lengths for each 64-bit half.
  typedef struct packed {
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic              v6;
    logic [LEN_W-1:0]  len_hi;
    logic [LEN_W-1:0]  len_lo;
  } csa_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    csa_entry_t       entry;
  } csa_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic              v6;
  } csa_probe_t;

  typedef struct packed {
    logic count_zero;
    logic listener_local;
    logic scan_done;
    logic scan_hit;
  } csa_status_t;

  // Top len bits set, len in 0..64.
  function automatic logic [ADDR_W-1:0] top_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    for (int b = 0; b < ADDR_W; b++) begin
      m[ADDR_W-1-b] = (LEN_W'(b) < len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/csa_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module csa_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       tok_in,
  input  wire logic                       hit_in,
  input  wire logic [csa_pkg::COUNT_W-1:0] count,
  input  wire csa_pkg::csa_wr_t           wr,
  input  wire csa_pkg::csa_probe_t        probe,
  output logic                            tok_out,
  output logic                            hit_out
);
  import csa_pkg::*;

  csa_entry_t entry;
  logic       sel;
  logic       active;
  logic       match;

  assign sel    = (CMP_W'(wr.index) == CMP_W'(CELL_INDEX));
  assign active = (CMP_W'(count) > CMP_W'(CELL_INDEX));

  assign match = (entry.v6 == probe.v6)
              && (((probe.hi ^ entry.hi) & top_mask(entry.len_hi)) == '0)
              && (((probe.lo ^ entry.lo) & top_mask(entry.len_lo)) == '0);

  always_ff @(posedge clk) begin
    if (wr.en && sel) begin
      entry <= wr.entry;
    end
  end

  // Pass the token one cell per cycle, folding in this slot's compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    hit_out <= hit_in | (tok_in & active & match);
  end

endmodule

`default_nettype wire

### rtl/csa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module csa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire logic                 mode,
  input  wire logic                 peer_present,
  input  wire csa_pkg::csa_status_t status,
  input  wire logic                 result_stall,
  output logic                      item_stall,
  output logic                      inject,
  output logic                      launch,
  output logic                      result_valid,
  output logic                      allowed,
  output logic [2:0]                verdict
);
  import csa_pkg::*;

  state_t   state;
  state_t   state_next;
  logic     accept;
  logic     out_free;
  logic     load;
  logic     load_allowed;
  verdict_t load_verdict;
  logic     hit_q;
  verdict_t verdict_q;

  assign out_free = ~result_valid | ~result_stall;
  assign accept   = item_valid & ~item_stall;
  assign verdict  = verdict_q;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (inject) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall   = (state != ST_IDLE) | (result_valid & result_stall);
    inject       = 1'b0;
    load         = 1'b0;
    load_allowed = 1'b0;
    load_verdict = VERDICT_NO_MATCH;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode) begin
            load         = 1'b1;
            load_verdict = VERDICT_WRITTEN;
          end else if (status.count_zero) begin
            load         = 1'b1;
            load_allowed = status.listener_local;
            load_verdict = status.listener_local ? VERDICT_EMPTY_LOCAL : VERDICT_EMPTY_NET;
          end else if (!peer_present) begin
            load         = 1'b1;
            load_verdict = VERDICT_NO_PEER;
          end else begin
            inject = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load         = 1'b1;
          load_allowed = hit_q;
          load_verdict = hit_q ? VERDICT_MATCHED : VERDICT_NO_MATCH;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      launch       <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= inject;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the result beat until the far side takes it.
  always_ff @(posedge clk) begin
    if (load) begin
      allowed   <= load_allowed;
      verdict_q <= load_verdict;
    end
    if (state == ST_SCAN && status.scan_done) begin
      hit_q <= status.scan_hit;
    end
  end

endmodule

`default_nettype wire

### rtl/cidr_source_allowlist.sv
`timescale 1ns / 1ps
`default_nettype none

// Source allowlist over IPv4/IPv6 prefixes. Each table slot lives in one cell
// of a chain; a check walks a token down the chain one cell per cycle, so a
// check against a non-empty list reaches its result beat once the token leaves
// the last cell. Table writes, checks with no peer and checks against an empty
// list answer straight from idle, with no walk. One item is in flight at a time;
// the next is taken once the previous result beat leaves the output register, at
// the earliest in the cycle it leaves. Configuration (entry_count at index 0,
// listener_local at index 1) is always ready; the user must write it only while
// idle, which the block itself does not enforce.
module cidr_source_allowlist #(
  parameter int TABLE_DEPTH = csa_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [csa_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        mode,
  input  wire logic [csa_pkg::IDX_W-1:0]   entry_index,
  input  wire logic [csa_pkg::ADDR_W-1:0]  addr_hi,
  input  wire logic [csa_pkg::ADDR_W-1:0]  addr_lo,
  input  wire logic                        addr_is_v6,
  input  wire logic [csa_pkg::PLEN_W-1:0]  prefix_len,
  input  wire logic                        peer_present,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic                             allowed,
  output logic [2:0]                       verdict
);
  import csa_pkg::*;

  logic [COUNT_W-1:0] entry_count;
  logic               listener_local;
  logic               accept;
  logic               inject;
  logic               launch;
  csa_status_t        status;
  csa_wr_t            wr;
  csa_probe_t         probe;
  logic [LEN_W-1:0]   len_hi;
  logic [LEN_W-1:0]   len_lo;
  logic [TABLE_DEPTH:0] tok;
  logic [TABLE_DEPTH:0] hit;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      listener_local <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENTRY_COUNT:    entry_count    <= cfg_data[COUNT_W-1:0];
        CFG_LISTENER_LOCAL: listener_local <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the prefix into per-half mask lengths once, at write time.
  always_comb begin
    len_lo = '0;
    if (addr_is_v6) begin
      len_hi = (prefix_len >= PLEN_HALF) ? LEN_W'(PLEN_HALF) : prefix_len[LEN_W-1:0];
      if (prefix_len >= PLEN_V6) begin
        len_lo = LEN_W'(PLEN_HALF);
      end else if (prefix_len > PLEN_HALF) begin
        len_lo = LEN_W'(prefix_len - PLEN_HALF);
      end
    end else begin
      len_hi = (prefix_len >= PLEN_V4) ? LEN_W'(PLEN_V4) : prefix_len[LEN_W-1:0];
    end
  end

  always_comb begin
    wr.en           = accept & mode;
    wr.index        = entry_index;
    wr.entry.hi     = addr_hi;
    wr.entry.lo     = addr_lo;
    wr.entry.v6     = addr_is_v6;
    wr.entry.len_hi = len_hi;
    wr.entry.len_lo = len_lo;
  end

  always_ff @(posedge clk) begin
    if (inject) begin
      probe.hi <= addr_hi;
      probe.lo <= addr_lo;
      probe.v6 <= addr_is_v6;
    end
  end

  assign tok[0] = launch;
  assign hit[0] = 1'b0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    csa_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[g]),
      .hit_in (hit[g]),
      .count  (entry_count),
      .wr     (wr),
      .probe  (probe),
      .tok_out(tok[g+1]),
      .hit_out(hit[g+1])
    );
  end

  always_comb begin
    status.count_zero     = (entry_count == '0);
    status.listener_local = listener_local;
    status.scan_done      = tok[TABLE_DEPTH];
    status.scan_hit       = hit[TABLE_DEPTH];
  end

  csa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .mode        (mode),
    .peer_present(peer_present),
    .status      (status),
    .result_stall(result_stall),
    .item_stall  (item_stall),
    .inject      (inject),
    .launch      (launch),
    .result_valid(result_valid),
    .allowed     (allowed),
    .verdict     (verdict)
  );

`include "cidr_source_allowlist_defines.svh"

  `CSA_ASSERT_NEXT(a_busy_after_start, clk, rst, inject, item_stall)
  `CSA_ASSERT_IMPLY(a_busy_while_walking, clk, rst, tok != '0, item_stall)
  `CSA_ASSERT_IMPLY(a_single_token, clk, rst, 1'b1, $onehot0(tok))
  `CSA_ASSERT_IMPLY(a_allowed_matches_verdict, clk, rst, result_valid, allowed == ((verdict == VERDICT_MATCHED) || (verdict == VERDICT_EMPTY_LOCAL)))

endmodule

`default_nettype wire

### tb/tb_cidr_source_allowlist.sv
`timescale 1ns / 1ps

module tb_cidr_source_allowlist;
  import csa_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int V4_LEN = PLEN_V4;
  localparam int V6_LEN = PLEN_V6;
  localparam int HALF_LEN = PLEN_HALF;
  localparam int NUM_PHASES = 20;
  localparam int PHASE_ITEMS = 85;
  localparam int WATCHDOG = 4000;
  localparam bit MODE_CHECK = 1'b0;
  localparam bit MODE_WRITE = 1'b1;

  typedef struct packed {
    bit              mode;
    bit [IDX_W-1:0]  idx;
    bit [ADDR_W-1:0] hi;
    bit [ADDR_W-1:0] lo;
    bit              v6;
    bit [PLEN_W-1:0] plen;
    bit              peer;
  } acl_item_t;

  typedef struct packed {
    bit       alw;
    verdict_t verdict;
  } acl_result_t;

  typedef struct {
    bit              is_cfg;
    bit [CFG_W-1:0]  count;
    bit              loopback;
    acl_item_t       item;
    bit              typed;
    acl_result_t     exp;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  cfg_reg_t cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  acl_item_t cur_item;
  logic result_valid;
  logic result_stall;
  logic allowed;
  logic [2:0] verdict;

  // expectation typed into the directed table for the beat being driven
  bit cur_typed;
  acl_result_t cur_exp;

  // predictor state
  bit [ADDR_W-1:0] tbl_hi [TABLE_DEPTH];
  bit [ADDR_W-1:0] tbl_lo [TABLE_DEPTH];
  bit [PLEN_W-1:0] tbl_plen [TABLE_DEPTH];
  bit              tbl_v6 [TABLE_DEPTH];
  bit [CFG_W-1:0]  acl_count;
  bit              acl_loopback;

  acl_result_t pending_verdicts[$];
  plan_row_t plan[$];

  bit quiet;
  int err_count;
  int idle_cycles;
  int results_seen;
  int rcv_seen;
  int rcv_wait;
  int n_items;
  int n_writes;
  int n_hits;
  int n_cfg;

  cidr_source_allowlist #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .mode        (cur_item.mode),
    .entry_index (cur_item.idx),
    .addr_hi     (cur_item.hi),
    .addr_lo     (cur_item.lo),
    .addr_is_v6  (cur_item.v6),
    .prefix_len  (cur_item.plen),
    .peer_present(cur_item.peer),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .allowed     (allowed),
    .verdict     (verdict)
  );

  always #1 clk = ~clk;

  function automatic bit [ADDR_W-1:0] top_bits(input int n);
    if (n <= 0) return '0;
    if (n >= ADDR_W) return '1;
    return ~({ADDR_W{1'b1}} >> n);
  endfunction

  function automatic bit slot_hit(input int s, input acl_item_t it);
    int p;
    p = tbl_plen[s];
    if (tbl_v6[s] != it.v6) return 1'b0;
    if (it.v6) begin
      if (p > V6_LEN) p = V6_LEN;
      return ((it.hi ^ tbl_hi[s]) & top_bits(p)) == '0 &&
             ((it.lo ^ tbl_lo[s]) & top_bits(p - HALF_LEN)) == '0;
    end
    if (p > V4_LEN) p = V4_LEN;
    return ((it.hi ^ tbl_hi[s]) & top_bits(p)) == '0;
  endfunction

  // Update the shadow table on writes and decide the verdict of one beat.
  function automatic acl_result_t acl_predict(input acl_item_t it);
    acl_result_t r;
    int n;
    r.alw = 1'b0;
    if (it.mode == MODE_WRITE) begin
      if (it.idx < TABLE_DEPTH) begin
        tbl_hi[it.idx] = it.hi;
        tbl_lo[it.idx] = it.lo;
        tbl_plen[it.idx] = it.plen;
        tbl_v6[it.idx] = it.v6;
      end
      r.verdict = VERDICT_WRITTEN;
    end else if (acl_count == 0) begin
      r.alw = acl_loopback;
      r.verdict = acl_loopback ? VERDICT_EMPTY_LOCAL : VERDICT_EMPTY_NET;
    end else if (!it.peer) begin
      r.verdict = VERDICT_NO_PEER;
    end else begin
      n = acl_count > TABLE_DEPTH ? TABLE_DEPTH : acl_count;
      r.verdict = VERDICT_NO_MATCH;
      for (int s = 0; s < n; s++) begin
        if (slot_hit(s, it)) begin
          r.alw = 1'b1;
          r.verdict = VERDICT_MATCHED;
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic bit [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic bit [PLEN_W-1:0] rand_plen(input bit v6);
    if ($urandom_range(0, 9) == 0) return PLEN_W'($urandom_range(0, 255));
    return v6 ? PLEN_W'($urandom_range(16, V6_LEN)) : PLEN_W'($urandom_range(8, V4_LEN));
  endfunction

  function automatic acl_item_t check_item(input bit [ADDR_W-1:0] hi,
                                           input bit [ADDR_W-1:0] lo,
                                           input bit v6, input bit peer);
    acl_item_t it;
    it = '0;
    it.mode = MODE_CHECK;
    it.hi = hi;
    it.lo = lo;
    it.v6 = v6;
    it.peer = peer;
    return it;
  endfunction

  function automatic acl_item_t write_item(input int idx, input bit [ADDR_W-1:0] hi,
                                           input bit [ADDR_W-1:0] lo, input bit v6,
                                           input int plen);
    acl_item_t it;
    it = '0;
    it.mode = MODE_WRITE;
    it.idx = IDX_W'(idx);
    it.hi = hi;
    it.lo = lo;
    it.v6 = v6;
    it.plen = PLEN_W'(plen);
    return it;
  endfunction

  function automatic void plan_cfg(input int count, input bit loopback);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.count = CFG_W'(count);
    row.loopback = loopback;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(input acl_item_t it, input bit typed,
                                    input bit alw, input verdict_t v);
    plan_row_t row;
    row = '{default: '0};
    row.item = it;
    row.typed = typed;
    row.exp.alw = alw;
    row.exp.verdict = v;
    plan.push_back(row);
  endfunction

  // Random beat: mostly probes built from a live entry, some writes and noise.
  function automatic acl_item_t gen_beat();
    acl_item_t it;
    int r;
    int s;
    int p;
    int b;
    int span;
    bit [ADDR_W-1:0] mh;
    bit [ADDR_W-1:0] ml;
    it = check_item(rand64(), rand64(), 1'($urandom_range(0, 1)), 1'b1);
    it.idx = IDX_W'($urandom);
    it.plen = PLEN_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 20) begin
      it = write_item($urandom_range(0, TABLE_DEPTH - 1), rand64(), rand64(),
                      1'($urandom_range(0, 1)), 0);
      it.plen = rand_plen(it.v6);
    end else if (r < 28) begin
      it.peer = 1'b0;
    end else if (r >= 38) begin
      span = (acl_count == 0 || acl_count > TABLE_DEPTH) ? TABLE_DEPTH : acl_count;
      s = $urandom_range(0, span - 1);
      it.v6 = tbl_v6[s];
      p = tbl_plen[s];
      if (it.v6 && p > V6_LEN) p = V6_LEN;
      if (!it.v6 && p > V4_LEN) p = V4_LEN;
      mh = top_bits(p);
      ml = it.v6 ? top_bits(p - HALF_LEN) : '0;
      it.hi = (tbl_hi[s] & mh) | (it.hi & ~mh);
      it.lo = (tbl_lo[s] & ml) | (it.lo & ~ml);
      // break the prefix by one bit now and then
      if (p > 0 && $urandom_range(0, 3) == 0) begin
        b = $urandom_range(0, p - 1);
        if (b < HALF_LEN) it.hi[ADDR_W-1-b] = ~it.hi[ADDR_W-1-b];
        else it.lo[2*ADDR_W-1-b] = ~it.lo[2*ADDR_W-1-b];
      end
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input acl_item_t it, input bit typed, input acl_result_t exp);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    cur_item <= it;
    cur_typed <= typed;
    cur_exp <= exp;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(input bit [CFG_W-1:0] count, input bit loopback);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_LISTENER_LOCAL;
    cfg_data <= CFG_W'(loopback);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // result side: stall for a drawn number of cycles after every result beat
  always @(negedge clk) begin
    if (results_seen != rcv_seen) begin
      rcv_seen = results_seen;
      rcv_wait = draw_gap();
    end
    if (rcv_wait > 0) begin
      result_stall <= 1'b1;
      rcv_wait--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    acl_result_t e;
    bit took;
    if (!rst) begin
      took = 1'b0;
      if (result_valid && !result_stall) begin
        took = 1'b1;
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("result beat with nothing expected: allowed=%0d verdict=%0d",
                 allowed, verdict);
          err_count++;
        end else begin
          e = pending_verdicts.pop_front();
          if (allowed !== e.alw) begin
            $error("allowed mismatch: expected %0d, got %0d", e.alw, allowed);
            err_count++;
          end
          if (verdict !== e.verdict) begin
            $error("verdict mismatch: expected %0d, got %0d", e.verdict, verdict);
            err_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        took = 1'b1;
        e = acl_predict(cur_item);
        n_items++;
        if (cur_item.mode == MODE_WRITE) n_writes++;
        if (e.verdict == VERDICT_MATCHED) n_hits++;
        pending_verdicts.push_back(cur_typed ? cur_exp : e);
      end
      if (cfg_valid && cfg_ready) begin
        took = 1'b1;
        case (cfg_index)
          CFG_ENTRY_COUNT: acl_count = cfg_data;
          CFG_LISTENER_LOCAL: acl_loopback = cfg_data[0];
          default: ;
        endcase
      end
      idle_cycles = took ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 WATCHDOG, pending_verdicts.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t row;
    acl_result_t none;
    acl_item_t wi;
    int order [TABLE_DEPTH];
    int j;
    int t;
    int cnt;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENTRY_COUNT;
    cfg_data = '0;
    item_valid = 1'b0;
    cur_item = '0;
    cur_typed = 1'b0;
    cur_exp = '0;
    result_stall = 1'b0;
    none = '0;

    // empty list on a network listener, then on a loopback one
    plan_cfg(0, 1'b0);
    plan_item(check_item(64'hC0A80001_00000000, '0, 1'b0, 1'b1), 1, 0, VERDICT_EMPTY_NET);
    plan_item(check_item('0, '0, 1'b0, 1'b0), 1, 0, VERDICT_EMPTY_NET);
    plan_cfg(0, 1'b1);
    plan_item(check_item('1, '1, 1'b1, 1'b1), 1, 1, VERDICT_EMPTY_LOCAL);
    plan_item(check_item('0, '0, 1'b0, 1'b0), 1, 1, VERDICT_EMPTY_LOCAL);
    // load entries: short, full, oversized and zero-length prefixes
    plan_item(write_item(0, 64'h0A000000_00000000, '0, 1'b0, 8), 1, 0, VERDICT_WRITTEN);
    plan_item(write_item(1, '1, '1, 1'b1, 128), 1, 0, VERDICT_WRITTEN);
    plan_item(write_item(2, 64'hC0A80101_DEADBEEF, 64'h1234, 1'b0, 255), 1, 0,
              VERDICT_WRITTEN);
    plan_item(write_item(3, '0, '0, 1'b1, 200), 1, 0, VERDICT_WRITTEN);
    plan_item(write_item(4, 64'h20010DB8_00000000, 64'h80000000_00000000, 1'b1, 65), 1, 0,
              VERDICT_WRITTEN);
    plan_item(write_item(5, '0, '0, 1'b0, 0), 1, 0, VERDICT_WRITTEN);
    plan_item(write_item(6, 64'h5A5A5A5A_A5A5A5A5, 64'h0F0F0F0F_F0F0F0F0, 1'b1, 0), 1, 0,
              VERDICT_WRITTEN);
    plan_cfg(5, 1'b0);
    plan_item(check_item(64'h0A010203_00000000, '0, 1'b0, 1'b0), 1, 0, VERDICT_NO_PEER);
    plan_item(check_item(64'h0A010203_00000000, '0, 1'b0, 1'b1), 0, 0, VERDICT_MATCHED);
    plan_item(check_item(64'h0B000000_00000000, '0, 1'b0, 1'b1), 0, 0, VERDICT_MATCHED);
    plan_item(check_item('1, '1, 1'b1, 1'b1), 0, 0, VERDICT_MATCHED);
    plan_item(check_item(64'hC0A80101_FFFFFFFF, '1, 1'b0, 1'b1), 0, 0, VERDICT_MATCHED);
    plan_item(check_item('0, '0, 1'b1, 1'b1), 0, 0, VERDICT_MATCHED);
    plan_item(check_item(64'h20010DB8_00000000, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 1'b1), 0, 0,
              VERDICT_MATCHED);
    plan_item(check_item(64'h20010DB8_00000000, 64'h7FFFFFFF_FFFFFFFF, 1'b1, 1'b1), 0, 0,
              VERDICT_MATCHED);
    plan_item(check_item(64'h0A000000_00000000, '0, 1'b1, 1'b1), 0, 0, VERDICT_MATCHED);
    plan_item(check_item('0, '0, 1'b0, 1'b1), 0, 0, VERDICT_MATCHED);
    plan_cfg(7, 1'b1);
    plan_item(check_item('1, '1, 1'b0, 1'b1), 0, 0, VERDICT_MATCHED);
    plan_item(check_item(64'h12345678_9ABCDEF0, 64'h0FEDCBA9_87654321, 1'b1, 1'b1), 0, 0,
              VERDICT_MATCHED);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) set_config(row.count, row.loopback);
      else send_beat(row.item, row.typed, row.exp);
    end

    // fill every slot in shuffled order so any count is legal from here on
    foreach (order[i]) order[i] = i;
    for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) begin
      wi = write_item(order[i], rand64(), rand64(), 1'($urandom_range(0, 1)), 0);
      wi.plen = rand_plen(wi.v6);
      send_beat(wi, 1'b0, none);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_config(64, 1'b0);
        1: set_config(127, 1'b1);
        2: set_config(1, 1'b0);
        3: set_config(0, 1'b0);
        4: set_config(0, 1'b1);
        5: set_config(65, 1'b0);
        default: begin
          t = $urandom_range(0, 9);
          if (t == 0) cnt = 0;
          else if (t == 1) cnt = $urandom_range(TABLE_DEPTH + 1, 127);
          else cnt = $urandom_range(1, TABLE_DEPTH);
          set_config(CFG_W'(cnt), 1'($urandom_range(0, 1)));
        end
      endcase
      quiet = (ph % 4 == 3);
      repeat (PHASE_ITEMS) send_beat(gen_beat(), 1'b0, none);
    end

    drain();
    repeat (TABLE_DEPTH + 8) @(negedge clk);
    $display("Drove %0d item beats: %0d table writes and %0d prefix matches",
             n_items, n_writes, n_hits);
    $display("Walked %0d register settings, entry_count 0 to 127, both listener kinds",
             n_cfg);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
